@@ sv/sdadc_pkg.sv @@
// Package: types and constants for the two-wire delta-sigma ADC frame controller.
`default_nettype none
package sdadc_pkg;

  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int COUNTER_WIDTH_DEF = 32;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_MISSED = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;

  localparam logic [2:0] REG_SETTING   = 3'd0;
  localparam logic [2:0] REG_POLL      = 3'd1;
  localparam logic [2:0] REG_PULSE     = 3'd2;
  localparam logic [2:0] REG_SYNC_POLL = 3'd3;
  localparam logic [2:0] REG_WAKE      = 3'd4;
  localparam logic [2:0] REG_TIMEOUT   = 3'd5;

  localparam logic [7:0] WRITE_CMD = 8'h65;
  localparam logic [7:0] READ_CMD  = 8'h56;

  typedef struct packed {
    logic [1:0] command;
    logic       dout_level;
  } in_beat_t;

  typedef struct packed {
    logic        sclk_level;
    logic        dout_drive;
    logic        dout_value;
    logic [1:0]  result_kind;
    logic signed [23:0] sample_value;
    logic [1:0]  error_code;
    logic        busy_res;
  } out_beat_t;

  typedef struct packed {
    logic [6:0]  adc_setting;
    logic [23:0] poll_interval;
    logic [7:0]  pulse_ticks;
    logic [15:0] sync_poll_interval;
    logic [15:0] wake_ticks;
    logic [31:0] ready_timeout;
  } cfg_regs_t;

endpackage
`default_nettype wire

@@ sv/sdadc_cfg.sv @@
// Configuration register file of the ADC frame controller.
`default_nettype none
module sdadc_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  output sdadc_pkg::cfg_regs_t  regs
);
  import sdadc_pkg::*;

  cfg_regs_t regs_r;
  assign regs = regs_r;

  // Write one register per beat; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.adc_setting        <= 7'd0;
      regs_r.poll_interval      <= 24'd1000;
      regs_r.pulse_ticks        <= 8'd8;
      regs_r.sync_poll_interval <= 16'd160;
      regs_r.wake_ticks         <= 16'd320;
      regs_r.ready_timeout      <= 32'd8000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTING:   regs_r.adc_setting        <= cfg_wdata[6:0];
        REG_POLL:      regs_r.poll_interval      <= cfg_wdata[23:0];
        REG_PULSE:     regs_r.pulse_ticks        <= cfg_wdata[7:0];
        REG_SYNC_POLL: regs_r.sync_poll_interval <= cfg_wdata[15:0];
        REG_WAKE:      regs_r.wake_ticks         <= cfg_wdata[15:0];
        REG_TIMEOUT:   regs_r.ready_timeout      <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/sdadc_seq.sv @@
// Tick sequencer: phase machine, pin levels and result beat for one tick.
`default_nettype none
module sdadc_seq #(
  parameter int SAMPLE_BITS   = sdadc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNTER_WIDTH = sdadc_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire sdadc_pkg::in_beat_t  in_beat,
  input  wire sdadc_pkg::cfg_regs_t regs,
  output sdadc_pkg::out_beat_t      out_beat
);
  import sdadc_pkg::*;

  localparam int FRAME_CLKS = SAMPLE_BITS + 3;
  localparam int SET_CLKS   = FRAME_CLKS + 19;
  localparam int CW = COUNTER_WIDTH;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_WR_READY, PH_WR_HIGH, PH_WR_LOW,
    PH_RD_READY, PH_RD_HIGH, PH_RD_LOW, PH_POLL, PH_FR_HIGH, PH_FR_LOW,
    PH_WAIT_HIGH
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [5:0]          bit_r, bit_nxt;
  logic [CW-1:0]       tick_r, tick_nxt;
  logic [SAMPLE_BITS-1:0] shift_r, shift_nxt;
  logic [1:0]          fstat_r, fstat_nxt;
  logic [7:0]          rdback_r, rdback_nxt;
  logic [1:0]          err_r, err_nxt;
  logic                whigh_r, whigh_nxt;

  // Limit a timing register into 1 .. counter max
  function automatic logic [CW-1:0] lim(input logic [31:0] v);
    logic [31:0] r;
    logic [31:0] cmax;
    begin
      cmax = 32'hFFFF_FFFF >> (32 - CW);
      r = (v == 32'd0) ? 32'd1 : v;
      if (r > cmax) r = cmax;
      return r[CW-1:0];
    end
  endfunction

  // Timer lengths
  logic [CW-1:0] len_wake, len_to, len_pulse, len_poll, len_sync;
  assign len_wake  = lim({16'd0, regs.wake_ticks});
  assign len_to    = lim(regs.ready_timeout);
  assign len_pulse = lim({24'd0, regs.pulse_ticks});
  assign len_poll  = lim({8'd0, regs.poll_interval});
  assign len_sync  = lim({16'd0, regs.sync_poll_interval});

  out_beat_t ob;
  phase_t    ph;
  logic [CW-1:0] tc, tinc, len;
  logic      hd, rd, dl;
  logic [5:0] bi, n;
  logic [7:0] cmdb;
  logic [SAMPLE_BITS-1:0] smp;

  always_comb begin
    ob = '0;
    dl = in_beat.dout_level;
    ph = phase_r; tc = tick_r; bi = bit_r;
    err_nxt = err_r; whigh_nxt = whigh_r;
    shift_nxt = shift_r; fstat_nxt = fstat_r; rdback_nxt = rdback_r;
    rd = 1'b0; n = 6'd0; cmdb = WRITE_CMD; smp = '0;
    // Apply command first
    if (in_beat.command == CMD_START || in_beat.command == CMD_STOP) begin
      ph = (in_beat.command == CMD_START) ? PH_WAKE : PH_IDLE;
      tc = '0; bi = 6'd0; err_nxt = ERR_NONE; whigh_nxt = 1'b0;
    end
    // Pick the timer length of this phase
    case (ph)
      PH_WAKE:                   len = len_wake;
      PH_WR_READY, PH_RD_READY:  len = len_to;
      PH_POLL:                   len = len_poll;
      PH_WAIT_HIGH:              len = len_sync;
      default:                   len = len_pulse;
    endcase
    tinc = tc + 1'b1;
    hd = (tinc >= len);
    tick_nxt = tc;
    if (ph != PH_IDLE) tick_nxt = hd ? '0 : tinc;
    phase_nxt = ph; bit_nxt = bi;
    case (ph)
      PH_WAKE: begin
        ob.busy_res = 1'b1;
        if (hd) phase_nxt = PH_WR_READY;
      end
      PH_WR_READY, PH_RD_READY: begin
        ob.busy_res = 1'b1;
        if (!dl) begin
          phase_nxt = (ph == PH_WR_READY) ? PH_WR_HIGH : PH_RD_HIGH;
          bit_nxt = 6'd1; tick_nxt = '0;
        end else if (hd) begin
          err_nxt = ERR_TIMEOUT; phase_nxt = PH_POLL;
        end
      end
      PH_WR_HIGH, PH_RD_HIGH, PH_WR_LOW, PH_RD_LOW: begin
        rd = (ph == PH_RD_HIGH) || (ph == PH_RD_LOW);
        ob.busy_res = 1'b1;
        ob.sclk_level = (ph == PH_WR_HIGH) || (ph == PH_RD_HIGH);
        cmdb = rd ? READ_CMD : WRITE_CMD;
        // Data pin drive for setting clock bi
        if (bi > 6'(FRAME_CLKS) && bi <= 6'(FRAME_CLKS + 19)) begin
          if (bi <= 6'(FRAME_CLKS + 2)) begin
            ob.dout_drive = 1'b1; ob.dout_value = 1'b1;
          end else if (bi <= 6'(FRAME_CLKS + 9)) begin
            n = 6'(FRAME_CLKS + 9) - bi;
            ob.dout_drive = 1'b1; ob.dout_value = cmdb[n[2:0]];
          end else if (bi == 6'(FRAME_CLKS + 10)) begin
            ob.dout_drive = !rd; ob.dout_value = !rd && cmdb[0];
          end else if (bi <= 6'(FRAME_CLKS + 18)) begin
            n = 6'(FRAME_CLKS + 18) - bi;
            ob.dout_drive = !rd;
            ob.dout_value = !rd && (n[2:0] != 3'd7) && regs.adc_setting[n[2:0]];
          end else begin
            ob.dout_drive = 1'b1;
            ob.dout_value = rd ? 1'b1 : regs.adc_setting[0];
          end
        end
        if (hd) begin
          if (ob.sclk_level) begin
            if (rd && bi > 6'(FRAME_CLKS + 10) && bi <= 6'(FRAME_CLKS + 18))
              rdback_nxt = {rdback_r[6:0], dl};
            phase_nxt = rd ? PH_RD_LOW : PH_WR_LOW;
          end else if (bi >= 6'(SET_CLKS)) begin
            bit_nxt = 6'd0;
            if (!rd) phase_nxt = PH_RD_READY;
            else begin
              if (rdback_r[6:0] != regs.adc_setting) err_nxt = ERR_MISMATCH;
              phase_nxt = PH_POLL;
            end
          end else begin
            bit_nxt = bi + 6'd1;
            phase_nxt = rd ? PH_RD_HIGH : PH_WR_HIGH;
          end
        end
      end
      PH_POLL: begin
        if (hd && !dl) begin
          if (err_nxt != ERR_NONE) ob.result_kind = KIND_ERROR;
          else begin
            phase_nxt = PH_FR_HIGH; bit_nxt = 6'd1;
            shift_nxt = '0; fstat_nxt = 2'd0;
          end
        end
      end
      PH_FR_HIGH: begin
        ob.busy_res = 1'b1; ob.sclk_level = 1'b1;
        if (hd) begin
          if (bi <= 6'(SAMPLE_BITS)) shift_nxt = {shift_r[SAMPLE_BITS-2:0], dl};
          else if (bi == 6'(SAMPLE_BITS + 1)) fstat_nxt = {1'b0, dl};
          else if (bi == 6'(SAMPLE_BITS + 2)) fstat_nxt = {dl, fstat_r[0]};
          phase_nxt = PH_FR_LOW;
        end
      end
      PH_FR_LOW: begin
        ob.busy_res = 1'b1;
        if (hd) begin
          if (bi >= 6'(FRAME_CLKS)) begin
            bit_nxt = 6'd0;
            if (fstat_r[1] || !dl) begin
              ob.result_kind = KIND_MISSED;
              if (!dl) begin
                whigh_nxt = 1'b1; phase_nxt = PH_WAIT_HIGH;
              end else phase_nxt = PH_POLL;
            end else begin
              smp = shift_r;
              ob.sample_value = 24'(signed'(smp));
              ob.result_kind = KIND_SAMPLE;
              phase_nxt = PH_POLL;
            end
          end else begin
            bit_nxt = bi + 6'd1;
            phase_nxt = PH_FR_HIGH;
          end
        end
      end
      PH_WAIT_HIGH: begin
        if (hd && dl) begin
          whigh_nxt = 1'b0; phase_nxt = PH_POLL;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        ob.sclk_level = 1'b1;
      end
    endcase
    ob.error_code = err_nxt;
  end

  assign out_beat = ob;

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bit_r <= '0; tick_r <= '0; shift_r <= '0;
      fstat_r <= '0; rdback_r <= '0; err_r <= ERR_NONE; whigh_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; bit_r <= bit_nxt; tick_r <= tick_nxt;
      shift_r <= shift_nxt; fstat_r <= fstat_nxt; rdback_r <= rdback_nxt;
      err_r <= err_nxt; whigh_r <= whigh_nxt;
    end
  end

`ifndef SYNTH
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 6'(SET_CLKS)) else $error("bit index past setting sequence");
  a_sample_only_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && ob.result_kind == KIND_SAMPLE |-> phase_r == PH_FR_LOW)
    else $error("sample outside frame end");
  a_wait_flag: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT_HIGH |-> whigh_r) else $error("wait phase without flag");
  a_drive_value: assert property (@(posedge clk) disable iff (!rst_n)
    !ob.dout_drive |-> !ob.dout_value) else $error("value while released");
`endif
endmodule
`default_nettype wire

@@ sv/sigma_delta_adc_frame_controller_unit.sv @@
// Top level of the two-wire delta-sigma ADC frame controller.
// Usage:
//  - in_valid/in_stall/in_data: one beat per timer tick (command, sampled
//    data pin). The tick is applied to the sequencer when accepted.
//  - out_valid/out_stall/out_data: one result beat per tick with pin levels,
//    result kind, sample, stored error and busy flag.
//  - cfg_we/cfg_index/cfg_wdata: register writes, to be made only while
//    idle; the block itself does not enforce this.
//  Throughput: one tick per cycle while the skid stage is not full; the phase
//  machine and its tick counter settle a whole tick combinationally between
//  the input and the result register. A one-entry skid stage behind the result
//  register lets the block take a tick while a finished result still waits.
//  Stall: while the skid stage is full, which only a receiver stall brings
//  about, in_stall rises and no tick is taken.
//  Reset (rst_n low, synchronous): powered-down idle, registers at default
//  values, no result pending.
`default_nettype none
module sigma_delta_adc_frame_controller_unit #(
  parameter int SAMPLE_BITS   = sdadc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNTER_WIDTH = sdadc_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sdadc_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sdadc_pkg::out_beat_t     out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);
  import sdadc_pkg::*;

  cfg_regs_t regs;
  out_beat_t res;
  logic      step;

  out_beat_t main_r, skid_r;
  logic      main_v_r, skid_v_r;

  assign in_stall = skid_v_r;
  assign step     = in_valid && !in_stall;

  sdadc_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .regs
  );

  sdadc_seq #(.SAMPLE_BITS(SAMPLE_BITS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_seq (
    .clk, .rst_n, .step, .in_beat(in_data), .regs, .out_beat(res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || !out_stall) begin
        main_v_r <= skid_v_r || step;
        skid_v_r <= 1'b0;
      end else if (step) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || !out_stall) main_r <= skid_v_r ? skid_r : res;
    else if (step) skid_r <= res;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

`ifndef SYNTH
  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid full with empty output");
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !step) else $error("tick taken with full skid");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("stalled result lost");
`endif
endmodule
`default_nettype wire
